[src/utd_pkg.sv]
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder package
// Shared result type, result kinds and result queue sizing.
// ----------------------------------------------------------------------------
package utd_pkg;

  // Result kinds
  localparam logic [1:0] KIND_UNIT  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;
  localparam logic [1:0] KIND_FULL  = 2'd3;

  // Result queue: one item causes at most two results.
  localparam int RES_DEPTH    = 4;
  localparam int RES_PTR_BITS = $clog2(RES_DEPTH);

  typedef struct packed {
    logic [15:0] code_unit;
    logic [15:0] char_count;
    logic [1:0]  kind;
    logic        last_result;
  } result_t;

  // Write request into the result queue: up to two results in order.
  typedef struct packed {
    logic [1:0]  count;
    result_t [1:0] item;
  } push_req_t;

endpackage

[src/utd_result_queue.sv]
// ----------------------------------------------------------------------------
// UTF-8 decoder result queue
// Small queue that takes up to two results per cycle and hands out one.
// ----------------------------------------------------------------------------
module utd_result_queue (
  input  logic               clk,
  input  logic               rst,
  input  utd_pkg::push_req_t push,
  input  logic               pop,
  output utd_pkg::result_t   head,
  output logic               not_empty,
  output logic               room
);
  import utd_pkg::*;

  result_t                 entries [RES_DEPTH];
  logic [RES_PTR_BITS-1:0] wr_ptr;
  logic [RES_PTR_BITS-1:0] rd_ptr;
  logic [RES_PTR_BITS:0]   fill;
  logic [RES_PTR_BITS:0]   fill_next;
  logic                    do_pop;

  assign do_pop    = pop && (fill != '0);
  assign not_empty = (fill != '0);
  assign head      = entries[rd_ptr];
  // Room for the worst case of two results from one transfer.
  assign room      = (fill <= (RES_PTR_BITS+1)'(RES_DEPTH - 2));

  always_comb begin
    fill_next = fill + (RES_PTR_BITS+1)'(push.count);
    if (do_pop) begin
      fill_next = fill_next - (RES_PTR_BITS+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + RES_PTR_BITS'(push.count);
      if (do_pop) begin
        rd_ptr <= rd_ptr + RES_PTR_BITS'(1);
      end
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.item[0];
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr + RES_PTR_BITS'(1)] <= push.item[1];
    end
  end

endmodule

[src/utf8_to_utf16_decoder_unit.sv]
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder unit
// Streams UTF-8 bytes of framed strings into 16-bit code units and reports.
// ----------------------------------------------------------------------------
// The unit takes one UTF-8 byte per transfer on the data channel, framed by
// first_byte and last_byte, and returns 16-bit code units (basic plane only,
// no surrogates) followed by one closing report per string on the result
// channel. A byte can be taken every clock cycle that data_ready is high.
// Its decode is a single pass of masking and counting between the decoder
// state registers and a four-entry result queue, so a result is available
// at the earliest in the cycle after the transfer that causes it. A byte
// yields at most two results (a unit and the closing report), and the queue
// drains at most one result per cycle. data_ready drops whenever the queue
// holds more than two results. That happens when the consumer stalls, and
// also when closing bytes that each give two results arrive back to back,
// since they make results faster than one per cycle. Leads of four to six
// bytes give the substitute unit 0xFF1F, bad leads (10xxxxxx, 0xFE, 0xFF)
// close the string with an error report, and a leading byte-order mark
// EF BB BF is dropped and not counted. When output_capacity is nonzero, the
// string is closed with a full report at the first lead found once that
// many characters have been converted; when it is zero, only the closing
// report is given. Bytes that arrive outside a string are taken and ignored.
module utf8_to_utf16_decoder_unit #(
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // byte input channel
  input  logic        data_valid,
  output logic        data_ready,
  input  logic [7:0]  data_byte,
  input  logic        first_byte,
  input  logic        last_byte,
  // result channel
  output logic        result_valid,
  input  logic        result_ready,
  output logic [15:0] code_unit,
  output logic [15:0] char_count,
  output logic [1:0]  kind,
  output logic        last_result
);
  import utd_pkg::*;

  // The count is compared against the 16-bit capacity at the wider width.
  localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  // Register word index taken from the byte address.
  localparam logic REG_OUTPUT_CAPACITY = 1'b0;

  // String phase codes.
  localparam logic [1:0] PHASE_IDLE   = 2'd0;
  localparam logic [1:0] PHASE_ACTIVE = 2'd1;
  localparam logic [1:0] PHASE_DONE   = 2'd2;

  // Sequence length announced by a lead byte; zero for an invalid lead.
  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    case (b) inside
      [8'h00:8'h7F]: len = 3'd1;
      [8'hC0:8'hDF]: len = 3'd2;
      [8'hE0:8'hEF]: len = 3'd3;
      [8'hF0:8'hF7]: len = 3'd4;
      [8'hF8:8'hFB]: len = 3'd5;
      [8'hFC:8'hFD]: len = 3'd6;
      default:       len = 3'd0;
    endcase
    return len;
  endfunction

  // Low 16 bits of the count, zero-extended when the count is narrower.
  function automatic logic [15:0] low16(input logic [COUNT_BITS-1:0] c);
    logic [CMP_W-1:0] w;
    w = CMP_W'(c);
    return w[15:0];
  endfunction

  // Configuration register
  logic [15:0] output_capacity;
  logic        cfg_write;

  // Decoder state registers
  logic [2:0]            bytes_pending;
  logic [2:0]            sequence_length;
  logic [15:0]           code_accumulator;
  logic [COUNT_BITS-1:0] converted_count;
  logic [1:0]            phase;
  logic                  mark_check_pending;

  logic [2:0]            bytes_pending_next;
  logic [2:0]            sequence_length_next;
  logic [15:0]           code_accumulator_next;
  logic [COUNT_BITS-1:0] converted_count_next;
  logic [1:0]            phase_next;
  logic                  mark_check_pending_next;

  // Single-pass decode signals
  logic        data_take;
  logic        live;
  logic [2:0]  lead_len;
  logic        closed;
  logic        char_go;
  logic        char_nomark;
  logic [15:0] char_value;
  logic        mark_skip;
  logic        unit_go;
  logic        fin_go;
  logic [1:0]  fin_kind;
  logic [15:0] fin_count;
  logic        cap_on;
  result_t     unit_res;
  result_t     fin_res;
  push_req_t   push;
  result_t     head;
  logic        queue_room;
  logic        queue_pop;

  // ------------------------------------------------------------------------
  // Configuration port. Writes complete in the access phase; pready is
  // always high, so there are no wait states.
  // ------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_capacity <= '0;
    end else if (cfg_write && (paddr[2] == REG_OUTPUT_CAPACITY)) begin
      output_capacity <= pwdata[15:0];
    end
  end

  assign prdata = (paddr[2] == REG_OUTPUT_CAPACITY) ? {16'h0000, output_capacity} : '0;

  assign cap_on = (output_capacity != 16'h0000);

  // ------------------------------------------------------------------------
  // Decode. All work for one byte is done here in one pass: restart on a
  // first byte, lead or continuation handling, the truncated-sequence close
  // on a last byte, and finally the character bookkeeping (mark drop and
  // saturating count). A byte makes at most one character.
  // ------------------------------------------------------------------------
  assign data_take = data_valid && data_ready;
  assign live      = first_byte || (phase == PHASE_ACTIVE);
  assign lead_len  = lead_length(data_byte);

  always_comb begin
    bytes_pending_next      = bytes_pending;
    sequence_length_next    = sequence_length;
    code_accumulator_next   = code_accumulator;
    converted_count_next    = converted_count;
    phase_next              = phase;
    mark_check_pending_next = mark_check_pending;
    closed      = 1'b0;
    char_go     = 1'b0;
    char_nomark = 1'b0;
    char_value  = 16'h0000;
    mark_skip   = 1'b0;
    unit_go     = 1'b0;
    fin_go      = 1'b0;
    fin_kind    = KIND_END;
    fin_count   = 16'h0000;

    if (first_byte) begin
      bytes_pending_next      = 3'd0;
      sequence_length_next    = 3'd1;
      code_accumulator_next   = 16'h0000;
      converted_count_next    = '0;
      phase_next              = PHASE_ACTIVE;
      mark_check_pending_next = (data_byte == 8'hEF);
    end

    if (bytes_pending_next == 3'd0) begin
      if (lead_len == 3'd0) begin
        // Invalid lead closes the string with an error report.
        fin_go     = 1'b1;
        fin_kind   = KIND_ERROR;
        fin_count  = 16'h0000;
        phase_next = PHASE_DONE;
        closed     = 1'b1;
      end else if (cap_on &&
                   (CMP_W'(converted_count_next) >= CMP_W'(output_capacity))) begin
        fin_go     = 1'b1;
        fin_kind   = KIND_FULL;
        fin_count  = low16(converted_count_next);
        phase_next = PHASE_DONE;
        closed     = 1'b1;
      end else begin
        sequence_length_next = lead_len;
        case (lead_len)
          3'd1: begin
            char_go    = 1'b1;
            char_value = {8'h00, data_byte};
          end
          3'd2: begin
            code_accumulator_next = {5'b00000, data_byte[4:0], 6'b000000};
            bytes_pending_next    = 3'd1;
          end
          3'd3: begin
            code_accumulator_next = {data_byte[3:0], 12'h000};
            bytes_pending_next    = 3'd2;
          end
          default: begin
            // Four- to six-byte lead: substitute unit now, skip the rest.
            char_go            = 1'b1;
            char_nomark        = 1'b1;
            char_value         = 16'hFF1F;
            bytes_pending_next = lead_len - 3'd1;
          end
        endcase
      end
    end else begin
      if ((sequence_length_next == 3'd3) && (bytes_pending_next == 3'd2)) begin
        code_accumulator_next = code_accumulator_next | {4'h0, data_byte[5:0], 6'b000000};
        if (data_byte != 8'hBB) begin
          mark_check_pending_next = 1'b0;
        end
      end else if (sequence_length_next <= 3'd3) begin
        code_accumulator_next = code_accumulator_next | {10'h000, data_byte[5:0]};
        if (data_byte != 8'hBF) begin
          mark_check_pending_next = 1'b0;
        end
      end
      bytes_pending_next = bytes_pending_next - 3'd1;
      if ((bytes_pending_next == 3'd0) && (sequence_length_next <= 3'd3)) begin
        char_go    = 1'b1;
        char_value = code_accumulator_next;
      end
    end

    if (last_byte && !closed) begin
      // A truncated sequence is closed with zeros for its missing bytes and
      // is never taken as a byte-order mark.
      if ((bytes_pending_next != 3'd0) && (sequence_length_next <= 3'd3)) begin
        mark_check_pending_next = 1'b0;
        char_go                 = 1'b1;
        char_value              = code_accumulator_next;
      end
      bytes_pending_next = 3'd0;
      fin_go             = 1'b1;
      fin_kind           = KIND_END;
      phase_next         = PHASE_DONE;
    end

    // Character bookkeeping: a pending mark swallows the character.
    mark_skip = char_go && !char_nomark && mark_check_pending_next;
    if (mark_skip) begin
      mark_check_pending_next = 1'b0;
    end else if (char_go) begin
      if (!(&converted_count_next)) begin
        converted_count_next = converted_count_next + COUNT_BITS'(1);
      end
      unit_go = cap_on;
    end

    if (fin_go && (fin_kind == KIND_END)) begin
      fin_count = low16(converted_count_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending      <= '0;
      sequence_length    <= 3'd1;
      code_accumulator   <= '0;
      converted_count    <= '0;
      phase              <= PHASE_IDLE;
      mark_check_pending <= 1'b0;
    end else if (data_take && live) begin
      bytes_pending      <= bytes_pending_next;
      sequence_length    <= sequence_length_next;
      code_accumulator   <= code_accumulator_next;
      converted_count    <= converted_count_next;
      phase              <= phase_next;
      mark_check_pending <= mark_check_pending_next;
    end
  end

  // ------------------------------------------------------------------------
  // Results of one transfer go into the queue in order: the unit first,
  // then the closing report.
  // ------------------------------------------------------------------------
  always_comb begin
    unit_res.code_unit   = char_value;
    unit_res.char_count  = low16(converted_count_next);
    unit_res.kind        = KIND_UNIT;
    unit_res.last_result = 1'b0;
    fin_res.code_unit    = 16'h0000;
    fin_res.char_count   = fin_count;
    fin_res.kind         = fin_kind;
    fin_res.last_result  = 1'b1;

    push.item[0] = unit_go ? unit_res : fin_res;
    push.item[1] = fin_res;
    if (data_take && live) begin
      push.count = {1'b0, unit_go} + {1'b0, fin_go};
    end else begin
      push.count = 2'd0;
    end
  end

  assign data_ready = queue_room;
  assign queue_pop  = result_ready;

  utd_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (queue_pop),
    .head      (head),
    .not_empty (result_valid),
    .room      (queue_room)
  );

  assign code_unit   = head.code_unit;
  assign char_count  = head.char_count;
  assign kind        = head.kind;
  assign last_result = head.last_result;

`ifndef SYNTHESIS
  // Input backpressure only comes from a queue holding undelivered results.
  a_ready_only_when_backlog: assert property (@(posedge clk) disable iff (rst)
    !data_ready |-> result_valid)
    else $error("data_ready low with an empty result queue");

  // Only a code unit is non-final; every report closes its string.
  a_final_matches_kind: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (last_result == (kind != KIND_UNIT)))
    else $error("last_result does not match the result kind");

  // A transfer in a string carrying last_byte closes the string.
  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    (data_take && live && last_byte) |=> (phase == PHASE_DONE))
    else $error("string not closed after its last byte");

  // Continuation bytes are only outstanding inside an open string.
  a_pending_in_string: assert property (@(posedge clk) disable iff (rst)
    (bytes_pending != 3'd0) |-> (phase == PHASE_ACTIVE))
    else $error("bytes pending outside an open string");
`endif

endmodule
